/* src/rcfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC channel frame parser package
// Shared constants, codes and types of the RC channel frame parser.
// ----------------------------------------------------------------------------
package rcfp_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int MAX_PAYLOAD  = 128;

	localparam int VAL_W  = 16;
	localparam int BC_W   = 8;
	localparam int CNT_W  = $clog2(NUM_CHANNELS + 1);
	localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int ELAPSED_W = 17;

	localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
	localparam logic [15:0] SAFE_RESET    = 16'd1500;
	localparam logic        REFRESH_RESET = 1'b1;
	localparam logic [7:0]  CHAR_COMMA    = 8'h2C;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_TICK = 2'd2,
		KIND_READ = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CFG_TIMEOUT = 2'd0,
		CFG_SAFE    = 2'd1,
		CFG_REFRESH = 2'd2
	} cfg_index_t;

	typedef logic [NUM_CHANNELS-1:0][VAL_W-1:0] chan_vec_t;

	// Frame status handed from the parser to the top level.
	typedef struct packed {
		logic             commit;
		logic             good;
		logic [CNT_W-1:0] token_count;
	} frame_info_t;

endpackage

/* src/rcfp_token_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC channel frame parser token converter
// Per-byte frame state: token phase, accumulator, sign, byte count and the
// pending channel values of the frame being received.
// ----------------------------------------------------------------------------
module rcfp_token_parser
	import rcfp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  kind_t         kind,
	input  logic [7:0]    data_byte,
	output frame_info_t   frame_info,
	output chan_vec_t     pending
);

	typedef enum logic [2:0] {
		PH_BETWEEN = 3'd0,
		PH_LEAD    = 3'd1,
		PH_SIGN    = 3'd2,
		PH_DIGITS  = 3'd3,
		PH_TAIL    = 3'd4
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [15:0]       accum_q, accum_d;
	logic              neg_q, neg_d;
	logic [CNT_W-1:0]  tc_q, tc_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [BC_W-1:0]   bc_q, bc_d;
	logic              nul_q, nul_d;
	logic              pend_wr;
	logic [VAL_W-1:0]  pend_val;
	chan_vec_t         pending_q;

	logic              is_digit;
	logic              is_ws;
	logic [19:0]       mac;

	function automatic logic [VAL_W-1:0] token_bits(logic [15:0] acc, logic neg);
		logic [VAL_W-1:0] r;
		if (neg) begin
			r = 16'd0 - acc;
		end else begin
			r = (acc > 16'd32767) ? 16'd32767 : acc;
		end
		return r;
	endfunction

	assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
	assign is_ws    = (data_byte == 8'h20) || ((data_byte >= 8'h09) && (data_byte <= 8'h0D));

	always_comb begin
		logic start;
		logic try_digit;
		logic wr_digit;
		phase_d   = phase_q;
		accum_d   = accum_q;
		neg_d     = neg_q;
		tc_d      = tc_q;
		slot_d    = slot_q;
		bc_d      = bc_q;
		nul_d     = nul_q;
		pend_wr   = 1'b0;
		pend_val  = '0;
		mac       = '0;
		start     = 1'b0;
		try_digit = 1'b0;
		wr_digit  = 1'b0;
		if (kind == KIND_BYTE) begin
			if (bc_q < BC_W'(MAX_PAYLOAD)) begin
				bc_d = bc_q + 1'b1;
			end
			if (!nul_q) begin
				if (data_byte == 8'h00) begin
					nul_d = 1'b1;
				end else if (data_byte == CHAR_COMMA) begin
					phase_d = PH_BETWEEN;
				end else begin
					if (phase_q == PH_BETWEEN) begin
						if (tc_q < CNT_W'(NUM_CHANNELS)) begin
							slot_d  = tc_q[SLOT_W-1:0];
							tc_d    = tc_q + 1'b1;
							accum_d = '0;
							neg_d   = 1'b0;
							phase_d = PH_LEAD;
							start   = 1'b1;
						end else begin
							phase_d = PH_TAIL;
						end
					end
					case (phase_d)
						PH_LEAD: begin
							if (is_ws) begin
								// Leading whitespace is skipped.
							end else if ((data_byte == 8'h2B) || (data_byte == 8'h2D)) begin
								neg_d   = (data_byte == 8'h2D);
								phase_d = PH_SIGN;
							end else begin
								try_digit = 1'b1;
							end
						end
						PH_SIGN, PH_DIGITS: try_digit = 1'b1;
						default: ;
					endcase
					if (try_digit) begin
						if (is_digit) begin
							mac = ({4'd0, accum_d} << 3) + ({4'd0, accum_d} << 1)
								+ {16'd0, data_byte[3:0]};
							accum_d  = (mac > 20'd32768) ? 16'd32768 : mac[15:0];
							phase_d  = PH_DIGITS;
							wr_digit = 1'b1;
						end else begin
							phase_d = PH_TAIL;
						end
					end
					pend_wr  = start || wr_digit;
					pend_val = wr_digit ? token_bits(accum_d, neg_d) : '0;
				end
			end
		end else if (kind == KIND_END) begin
			phase_d = PH_BETWEEN;
			accum_d = '0;
			neg_d   = 1'b0;
			tc_d    = '0;
			slot_d  = '0;
			bc_d    = '0;
			nul_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_BETWEEN;
			accum_q   <= '0;
			neg_q     <= 1'b0;
			tc_q      <= '0;
			slot_q    <= '0;
			bc_q      <= '0;
			nul_q     <= 1'b0;
			pending_q <= '0;
		end else if (item_valid) begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			neg_q   <= neg_d;
			tc_q    <= tc_d;
			slot_q  <= slot_d;
			bc_q    <= bc_d;
			nul_q   <= nul_d;
			if (pend_wr) begin
				pending_q[slot_d] <= pend_val;
			end
		end
	end

	assign frame_info.commit      = item_valid && (kind == KIND_END)
		&& (bc_q < BC_W'(MAX_PAYLOAD));
	assign frame_info.good        = (tc_q == CNT_W'(NUM_CHANNELS));
	assign frame_info.token_count = tc_q;
	assign pending                = pending_q;

endmodule

/* src/rcfp_link_timer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC channel frame parser link timer
// Saturating millisecond counter and the link-alive compare.
// ----------------------------------------------------------------------------
module rcfp_link_timer
	import rcfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick,
	input  logic        refresh,
	input  logic [15:0] limit_ms,
	output logic        link_alive
);

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;

	always_comb begin
		elapsed_d = elapsed_q;
		if (refresh) begin
			elapsed_d = '0;
		end else if (tick && (elapsed_q != ELAPSED_MAX)) begin
			elapsed_d = elapsed_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
		end else begin
			elapsed_q <= elapsed_d;
		end
	end

	// Status reflects the counter after the current transaction.
	assign link_alive = (elapsed_d <= {{(ELAPSED_W-16){1'b0}}, limit_ms});

endmodule

/* src/rc_channel_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC channel frame parser
// Parses comma-separated decimal channel frames, keeps live channel values,
// a link timer and answers channel reads; one result per input transaction.
// ----------------------------------------------------------------------------
// Pipeline: a transaction sits in the input register and its result is then
// loaded into the result register.
// Throughput: one transaction per cycle while the output is not stalled; with the output stalled the input
// register and the result register hold two transactions before ready drops.
// Reset: arst_n clears all channel values, frame state and the link timer,
// and loads the configuration registers with their defaults.
module rc_channel_frame_parser
	import rcfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte[7:0], channel_index[15:8]
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // frame_ok[0], link_alive[1], read_value[17:2]
	output logic        m_axis_tlast,  // frame_done
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic        s1_valid;
	kind_t       s1_kind;
	logic [7:0]  s1_byte;
	logic [7:0]  s1_idx;
	logic        advance;

	logic [15:0] timeout_q;
	logic [15:0] safe_q;
	logic        refresh_any_q;

	chan_vec_t   live_q;
	chan_vec_t   pending;
	frame_info_t frame_info;
	logic        good_q, good_d;
	logic        refresh;
	logic        alive;
	logic [15:0] read_d;

	logic        out_valid_q;
	logic        out_done_q;
	logic        out_ok_q;
	logic        out_alive_q;
	logic [15:0] out_read_q;

	assign advance       = s1_valid && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			s1_kind <= kind_t'(s_axis_tuser);
			s1_byte <= s_axis_tdata[7:0];
			s1_idx  <= s_axis_tdata[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= TIMEOUT_RESET;
			safe_q        <= SAFE_RESET;
			refresh_any_q <= REFRESH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMEOUT: timeout_q     <= cfg_wdata;
				CFG_SAFE:    safe_q        <= cfg_wdata;
				CFG_REFRESH: refresh_any_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	rcfp_token_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (advance),
		.kind       (s1_kind),
		.data_byte  (s1_byte),
		.frame_info (frame_info),
		.pending    (pending)
	);

	assign good_d  = frame_info.commit ? frame_info.good : good_q;
	assign refresh = frame_info.commit && (refresh_any_q || frame_info.good);

	rcfp_link_timer u_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (advance && (s1_kind == KIND_TICK)),
		.refresh    (refresh),
		.limit_ms   (timeout_q),
		.link_alive (alive)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			good_q <= 1'b0;
		end else begin
			good_q <= good_d;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (frame_info.commit && (CNT_W'(i) < frame_info.token_count)) begin
					live_q[i] <= pending[i];
				end
			end
		end
	end

	always_comb begin
		read_d = '0;
		if (s1_kind == KIND_READ) begin
			if (s1_idx < 8'(NUM_CHANNELS)) begin
				read_d = live_q[s1_idx[SLOT_W-1:0]];
			end else begin
				read_d = safe_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_done_q  <= frame_info.commit;
			out_ok_q    <= good_d;
			out_alive_q <= alive;
			out_read_q  <= read_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_done_q;
	assign m_axis_tdata  = {6'd0, out_read_q, out_alive_q, out_ok_q};

endmodule

/* src/rcfp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC channel frame parser checker
// Port-level assertions on transaction flow, bound to the top level.
// ----------------------------------------------------------------------------
module rcfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] inflight_q;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Transactions taken in whose results have not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (inflight_q != 2'd0))
		else $error("result with no transaction in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 2'd2)
		else $error("more transactions in flight than the pipeline holds");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == 2'd0) |-> s_axis_tready)
		else $error("input stalled while the block is empty");

endmodule

bind rc_channel_frame_parser rcfp_checker u_rcfp_checker (.*);
